/* hw/rtl/scs_pkg.sv */
// Shared types and constants for the stick calibration and scaling block.
package scs_pkg;

    // Channel tag width, the fixed battery channel and the stick limit
    localparam int unsigned     CH_BITS         = 3;
    localparam logic [CH_BITS-1:0] BATTERY_CHANNEL = 3'd7;
    localparam int unsigned     MAX_STICKS      = 7;

    // Action codes of an input beat
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    // Percent scaling: full scale, its width, quotient and result widths
    localparam int unsigned FULL_SCALE = 100;
    localparam int unsigned SCALE_BITS = 7;
    localparam int unsigned Q_BITS     = 8;
    localparam int unsigned PCT_BITS   = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted input beat
        logic update;     // calibration and battery update, numerator and divisor
        logic mult;       // numerator times full scale
        logic div_init;   // overflow precheck, seed the remainder
        logic div_step;   // one restoring division step
        logic finish;     // write the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;   // stick sample that needs the divider
    } t_stat;

endpackage

/* hw/rtl/scs_if.sv */
// Valid/ready channel interfaces for input beats and result beats.
interface scs_in_if #(
    parameter int unsigned SAMPLE_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [scs_pkg::CH_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0]        raw_sample;
    logic                          capture_mid;
    logic [SAMPLE_BITS-1:0]        load_low;
    logic [SAMPLE_BITS-1:0]        load_mid;
    logic [SAMPLE_BITS-1:0]        load_high;

    modport source (
        output valid, action, channel, raw_sample, capture_mid,
               load_low, load_mid, load_high,
        input  ready
    );
    modport sink (
        input  valid, action, channel, raw_sample, capture_mid,
               load_low, load_mid, load_high,
        output ready
    );
endinterface

interface scs_out_if #(
    parameter int unsigned SAMPLE_BITS = 10
);
    logic                                 valid;
    logic                                 ready;
    logic [scs_pkg::CH_BITS-1:0]          out_channel;
    logic signed [scs_pkg::PCT_BITS-1:0]  scaled_percent;
    logic [SAMPLE_BITS-1:0]               battery_level;
    logic                                 limit_hit;

    modport source (
        output valid, out_channel, scaled_percent, battery_level, limit_hit,
        input  ready
    );
    modport sink (
        input  valid, out_channel, scaled_percent, battery_level, limit_hit,
        output ready
    );
endinterface

/* hw/rtl/scs_ctrl.sv */
// Controller state machine: sequences one item through the datapath.
module scs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  scs_pkg::t_stat   i_stat,
    output scs_pkg::t_cmd    o_cmd
);

    localparam int unsigned CNT_W = $clog2(scs_pkg::Q_BITS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UPDATE = 6'b000010,
        S_MULT   = 6'b000100,
        S_DINIT  = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    scs_pkg::t_cmd      cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                n_state    = i_stat.need_div ? S_MULT : S_FINISH;
            end
            S_MULT: begin
                cmd.mult = 1'b1;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(scs_pkg::Q_BITS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

/* hw/rtl/scs_dpath.sv */
// Datapath: calibration points, battery filter, serial divider, output register.
module scs_dpath #(
    parameter int unsigned STICK_CHANNELS = 7,
    parameter int unsigned SAMPLE_BITS    = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    input  scs_pkg::t_cmd                        i_cmd,
    output scs_pkg::t_stat                       o_stat,
    input  logic                                 i_action,
    input  logic [scs_pkg::CH_BITS-1:0]          i_channel,
    input  logic [SAMPLE_BITS-1:0]               i_raw_sample,
    input  logic                                 i_capture_mid,
    input  logic [SAMPLE_BITS-1:0]               i_load_low,
    input  logic [SAMPLE_BITS-1:0]               i_load_mid,
    input  logic [SAMPLE_BITS-1:0]               i_load_high,
    output logic [scs_pkg::CH_BITS-1:0]          o_out_channel,
    output logic signed [scs_pkg::PCT_BITS-1:0]  o_scaled_percent,
    output logic [SAMPLE_BITS-1:0]               o_battery_level,
    output logic                                 o_limit_hit
);

    localparam int unsigned SB        = SAMPLE_BITS;
    localparam int unsigned CAL_DEPTH = (STICK_CHANNELS < scs_pkg::MAX_STICKS) ?
                                        STICK_CHANNELS : scs_pkg::MAX_STICKS;
    localparam int unsigned IDX_W     = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
    localparam int unsigned QB        = scs_pkg::Q_BITS;
    localparam int unsigned PB        = scs_pkg::PCT_BITS;
    localparam int unsigned PROD_W    = SB + scs_pkg::SCALE_BITS;
    localparam logic [SB-1:0] MID_RST  = SB'(512);
    localparam logic [SB-1:0] HIGH_RST = SB'(1023);

    // Configuration
    logic r_ext;

    // Captured input beat
    logic                          r_action;
    logic [scs_pkg::CH_BITS-1:0]   r_ch;
    logic [SB-1:0]                 r_s;
    logic                          r_cap;
    logic [SB-1:0]                 r_ld_low, r_ld_mid, r_ld_high;

    // Calibration points and battery average
    logic [SB-1:0] r_cal_low  [CAL_DEPTH];
    logic [SB-1:0] r_cal_mid  [CAL_DEPTH];
    logic [SB-1:0] r_cal_high [CAL_DEPTH];
    logic [SB-1:0] r_bat;

    // Scaling operands and divider state
    logic [SB-1:0]     r_num, r_den;
    logic              r_neg, r_zero, r_sat, r_sample_op, r_over;
    logic [PROD_W-1:0] r_prod;
    logic [SB-1:0]     r_rem;
    logic [QB-1:0]     r_dvd, r_q;

    // Output register
    logic [scs_pkg::CH_BITS-1:0] r_out_ch;
    logic [PB-1:0]               r_out_pct;
    logic [SB-1:0]               r_out_bat;
    logic                        r_out_hit;

    // Item decode and calibration update
    logic              is_bat, is_stick, sample_op;
    logic [IDX_W-1:0]  idx;
    logic [SB-1:0]     lo, mid, hi, lo_n, mid_n, hi_n;
    logic              neg, pos, den_pos;
    logic [SB-1:0]     num, den;
    logic [SB+1:0]     bat_sum;

    always_comb begin
        is_bat    = (r_ch == scs_pkg::BATTERY_CHANNEL);
        is_stick  = !is_bat && (r_ch < scs_pkg::CH_BITS'(CAL_DEPTH));
        sample_op = is_stick && (r_action == scs_pkg::ACT_SAMPLE);
        idx       = is_stick ? r_ch[IDX_W-1:0] : '0;
        lo        = r_cal_low[idx];
        mid       = r_cal_mid[idx];
        hi        = r_cal_high[idx];
        lo_n      = (r_ext && (r_s < lo)) ? r_s : lo;
        hi_n      = (r_ext && (r_s > hi)) ? r_s : hi;
        mid_n     = r_cap ? r_s : mid;
        neg       = (r_s < mid_n);
        pos       = (r_s > mid_n);
        num       = neg ? (mid_n - r_s) : (r_s - mid_n);
        den       = neg ? (mid_n - lo_n) : (hi_n - mid_n);
        den_pos   = neg ? (mid_n > lo_n) : (hi_n > mid_n);
        bat_sum   = {2'b00, r_bat} + {1'b0, r_bat, 1'b0} + {2'b00, r_s};
    end

    assign o_stat.need_div = sample_op && (neg || pos) && den_pos;

    // Divider step: compare and subtract on the shifted remainder; overflow precheck
    logic [SB:0] trial_in, trial;
    logic        trial_ge;
    logic        dinit_over;

    always_comb begin
        trial_in   = {r_rem, r_dvd[QB-1]};
        trial      = trial_in - {1'b0, r_den};
        trial_ge   = (trial_in >= {1'b0, r_den});
        dinit_over = ({1'b0, r_prod[PROD_W-1:QB]} >= r_den);
    end

    // Result forming
    logic          q_big, res_hit;
    logic [PB-1:0] mag, pct;

    always_comb begin
        q_big   = r_over || (r_q > QB'(scs_pkg::FULL_SCALE));
        res_hit = r_sample_op && !r_zero && (r_sat || q_big);
        mag     = (r_sat || q_big) ? PB'(scs_pkg::FULL_SCALE) : PB'(r_q);
        if (!r_sample_op || r_zero) begin
            pct = '0;
        end else begin
            pct = r_neg ? (~mag + 1'b1) : mag;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ext <= i_cfg_wr_data;
        end
    end

    // Input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_ch      <= i_channel;
            r_s       <= i_raw_sample;
            r_cap     <= i_capture_mid;
            r_ld_low  <= i_load_low;
            r_ld_mid  <= i_load_mid;
            r_ld_high <= i_load_high;
        end
    end

    // Calibration points and battery filter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAL_DEPTH; i++) begin
                r_cal_low[i]  <= '0;
                r_cal_mid[i]  <= MID_RST;
                r_cal_high[i] <= HIGH_RST;
            end
            r_bat <= '0;
        end else if (i_cmd.update) begin
            if (is_bat && (r_action == scs_pkg::ACT_SAMPLE)) begin
                r_bat <= bat_sum[SB+1:2];
            end
            if (is_stick && (r_action == scs_pkg::ACT_LOAD)) begin
                r_cal_low[idx]  <= r_ld_low;
                r_cal_mid[idx]  <= r_ld_mid;
                r_cal_high[idx] <= r_ld_high;
            end else if (sample_op) begin
                r_cal_low[idx]  <= lo_n;
                r_cal_mid[idx]  <= mid_n;
                r_cal_high[idx] <= hi_n;
            end
        end
    end

    // Scaling operands, product and serial divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_num       <= num;
            r_den       <= den;
            r_neg       <= neg;
            r_zero      <= !(neg || pos);
            r_sat       <= !den_pos;
            r_sample_op <= sample_op;
        end
        if (i_cmd.mult) begin
            r_prod <= {{scs_pkg::SCALE_BITS{1'b0}}, r_num}
                      * PROD_W'(scs_pkg::FULL_SCALE);
        end
        if (i_cmd.div_init) begin
            r_over <= dinit_over;
            r_rem  <= {1'b0, r_prod[PROD_W-1:QB]};
            r_dvd  <= r_prod[QB-1:0];
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial[SB-1:0] : trial_in[SB-1:0];
            r_dvd <= {r_dvd[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], trial_ge};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_ch  <= r_ch;
            r_out_pct <= pct;
            r_out_bat <= r_bat;
            r_out_hit <= res_hit;
        end
    end

    assign o_out_channel    = r_out_ch;
    assign o_scaled_percent = r_out_pct;
    assign o_battery_level  = r_out_bat;
    assign o_limit_hit      = r_out_hit;

endmodule

/* hw/rtl/stick_calibrate_and_scale.sv */
// Top level: stick calibration, percent scaling and battery smoothing.
//
// Input channel i_in carries one beat per converter sample, tagged with its
// channel: channels below STICK_CHANNELS (at most 0 to 6) are sticks, channel
// 7 is the battery. action selects sample processing or a load of one
// stick's low, middle and high calibration points. Every input beat yields
// exactly one result beat on o_out, in order.
// i_cfg_wr_en/i_cfg_wr_data write extend_borders; write it only while idle.
// Items are handled one at a time. A stick sample that needs a quotient passes
// from acceptance through an update step, a multiply step, a precheck step,
// the restoring divider (one quotient bit per cycle) and the output register.
// Battery, load, unused-channel, zero-numerator and saturated items skip the
// divider. i_in.ready rises with the result, so a new item is accepted only
// once the last one has reached the output register.
// The output register holds a finished beat while the receiver stalls; the
// next item is accepted and worked on meanwhile and waits only at its final
// step for the register to free up.
// Reset (i_rst_n low, synchronous) sets low points to 0, middle points to 512,
// high points to 1023, the battery average and extend_borders to 0, and
// empties the output register.
module stick_calibrate_and_scale #(
    parameter int unsigned STICK_CHANNELS = 7,
    parameter int unsigned SAMPLE_BITS    = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    scs_in_if.sink     i_in,
    scs_out_if.source  o_out
);

    scs_pkg::t_cmd  cmd;
    scs_pkg::t_stat stat;

    // Sequencing
    scs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic
    scs_dpath #(
        .STICK_CHANNELS (STICK_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_in.action),
        .i_channel        (i_in.channel),
        .i_raw_sample     (i_in.raw_sample),
        .i_capture_mid    (i_in.capture_mid),
        .i_load_low       (i_in.load_low),
        .i_load_mid       (i_in.load_mid),
        .i_load_high      (i_in.load_high),
        .o_out_channel    (o_out.out_channel),
        .o_scaled_percent (o_out.scaled_percent),
        .o_battery_level  (o_out.battery_level),
        .o_limit_hit      (o_out.limit_hit)
    );

endmodule
